// ===== rtl/pal_pkg.sv =====
// types and codes shared by the positional array list modules
package pal_pkg;

  // operation codes carried in the action field
  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_INSERT = 2'd2;
  localparam logic [1:0] ACT_REMOVE = 2'd3;

  // request transaction
  typedef struct packed {
    logic        [1:0]  action;
    logic        [7:0]  position;
    logic signed [31:0] value;
  } in_item_t;

  // response transaction
  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic        [6:0]  count;
    logic               is_empty;
    logic               is_full;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic execute;
  } ctl_cmd_t;

endpackage

// ===== rtl/pal_ctrl.sv =====
// controller: tracks the held request and the response register
module pal_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output pal_pkg::ctl_cmd_t cmd
);
  import pal_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic execute;
  logic load_item;

  // execute the held request when the response register is free or draining
  assign execute   = (state == ST_HOLD) && (!out_valid || !out_stall);
  assign in_stall  = (state == ST_HOLD) && !execute;
  assign load_item = in_valid && !in_stall;

  assign cmd.load_item = load_item;
  assign cmd.execute   = execute;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (load_item) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (load_item) state_next = ST_HOLD;
        else if (execute) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // response valid flag
  always_comb begin
    if (execute) out_valid_next = 1'b1;
    else if (out_valid && !out_stall) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // an accepted request is held for execution
  a_load_holds: assert property (@(posedge clk) disable iff (rst)
    load_item |=> state == ST_HOLD)
    else $error("accepted request not held");

  // a held request waits until it executes
  a_hold_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) && !execute |=> state == ST_HOLD)
    else $error("held request dropped");

  // every execution produces a pending response
  a_exec_resp: assert property (@(posedge clk) disable iff (rst)
    execute |=> out_valid)
    else $error("execution without response");

endmodule

// ===== rtl/pal_datapath.sv =====
// datapath: row of entry cells, entry count, request and response registers
module pal_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  pal_pkg::ctl_cmd_t  cmd,
  input  pal_pkg::in_item_t  in_data,
  output pal_pkg::out_item_t out_data
);
  import pal_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = (CW > 8) ? CW + 1 : 9;

  in_item_t          req;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic signed [31:0] cells      [CAPACITY];
  logic signed [31:0] cells_next [CAPACITY];
  out_item_t         rsp_next;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] idx;
  logic          pos_nz;
  logic          in_range;
  logic          rd_ok;
  logic          wr_ok;
  logic          ins_ok;
  logic          rem_ok;

  // request register
  always_ff @(posedge clk) begin
    if (cmd.load_item) req <= in_data;
  end

  // bounds checks on the held request
  assign pos_ext  = PW'(req.position);
  assign cnt_ext  = PW'(count);
  assign idx      = pos_ext - PW'(1);
  assign pos_nz   = (req.position != 8'd0);
  assign in_range = pos_nz && (pos_ext <= cnt_ext);
  assign rd_ok    = (req.action == ACT_READ) && in_range;
  assign wr_ok    = (req.action == ACT_WRITE) && in_range;
  assign ins_ok   = (req.action == ACT_INSERT) && pos_nz
                    && (cnt_ext < PW'(CAPACITY)) && (pos_ext <= cnt_ext + PW'(1));
  assign rem_ok   = (req.action == ACT_REMOVE) && in_range;

  // each cell takes its own value, a neighbor's, or the request value
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_next[i] = cells[i];
      if (wr_ok && (PW'(i) == idx)) begin
        cells_next[i] = req.value;
      end else if (ins_ok) begin
        if (PW'(i) == idx) cells_next[i] = req.value;
        else if ((PW'(i) > idx) && (i > 0)) cells_next[i] = cells[(i > 0) ? i - 1 : 0];
      end else if (rem_ok && (PW'(i) >= idx) && (i < CAPACITY - 1)) begin
        cells_next[i] = cells[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  // count update
  always_comb begin
    count_next = count;
    if (ins_ok) count_next = count + CW'(1);
    else if (rem_ok) count_next = count - CW'(1);
  end

  // response fields
  always_comb begin
    rsp_next.ok         = rd_ok || wr_ok || ins_ok || rem_ok;
    rsp_next.read_value = rd_ok ? cells[idx[AW-1:0]] : 32'sd0;
    rsp_next.count      = 7'(count_next);
    rsp_next.is_empty   = (count_next == '0);
    rsp_next.is_full    = (count_next == CW'(CAPACITY));
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < CAPACITY; i++) cells[i] <= cells_next[i];
      out_data <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.execute) count <= count_next;
  end

  // count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a successful remove shrinks the list by one
  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && rem_ok |=> count == $past(count) - CW'(1))
    else $error("remove did not shrink the list");

  // read and write leave the count unchanged
  a_rw_count: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && ((req.action == ACT_READ) || (req.action == ACT_WRITE))
    |=> $stable(count))
    else $error("read or write changed the count");

endmodule

// ===== rtl/positional_array_list.sv =====
// top level of the positional array list
//
// An ordered list of up to CAPACITY signed 32-bit entries addressed by
// 1-based positions. Each request transaction on the in channel carries an
// action (read, write, insert, remove), a position and a value; each one
// yields exactly one response transaction on the out channel with the ok
// flag, the read value, and the count, empty and full flags after it.
// Both channels use valid and stall; a transaction moves at a clock edge
// where valid is high and stall is low.
// A request accepted into the request register executes once the response
// register is free or draining, and its response is offered from then on.
// Throughput is one transaction per cycle while out_stall stays low: the
// request register and the response register sit on either side of the
// execute step, where insert and remove shift the whole row of entry cells.
// When the receiver stalls, the response register holds its transaction,
// one further request may still be accepted and waits in the request
// register, then in_stall rises until the response drains.
// Reset empties the list (count zero) and drops any pending transaction;
// entry contents are not cleared and need no clearing pass.
module positional_array_list #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pal_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pal_pkg::out_item_t out_data
);
  import pal_pkg::*;

  ctl_cmd_t cmd;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pal_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
